[rtl/c3c_pkg.sv]
package c3c_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int COL_ADDR_W = $clog2(MAX_WIDTH);

   localparam int COL_W      = 11;
   localparam int ROW_W      = 12;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 8;
   localparam int KROW_W     = 3 * COEF_W;
   localparam int SHIFT_W    = 3;

   // pixel (zero-extended to 9 bits) times signed coefficient
   localparam int PROD_W     = PIX_W + COEF_W + 1;
   localparam int ROW_SUM_W  = PROD_W + 1;
   localparam int TOTAL_W    = ROW_SUM_W + 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_FRAC_SHIFT   = 3'd5;

   localparam logic [COL_W-1:0]   RST_IMAGE_WIDTH  = 11'd1024;
   localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT = 12'd1024;
   localparam logic [KROW_W-1:0]  RST_KERNEL_TOP   = 24'd65791;
   localparam logic [KROW_W-1:0]  RST_KERNEL_MID   = 24'd131326;
   localparam logic [KROW_W-1:0]  RST_KERNEL_BOT   = 24'd65791;
   localparam logic [SHIFT_W-1:0] RST_FRAC_SHIFT   = 3'd0;

   localparam logic [PIX_W-1:0]   PIX_MAX          = 8'd255;

   typedef struct packed {
      logic [COL_W-1:0]   image_width;
      logic [ROW_W-1:0]   image_height;
      logic [KROW_W-1:0]  kernel_top;
      logic [KROW_W-1:0]  kernel_mid;
      logic [KROW_W-1:0]  kernel_bot;
      logic [SHIFT_W-1:0] frac_shift;
   } cfg_type;

endpackage

[rtl/c3c_line_buffer.sv]
module c3c_line_buffer (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [c3c_pkg::COL_ADDR_W-1:0] wr_addr,
   input  logic [c3c_pkg::PIX_W-1:0]      wr_data,
   input  logic [c3c_pkg::COL_ADDR_W-1:0] rd_addr,
   output logic [c3c_pkg::PIX_W-1:0]      rd_data
);

   logic [c3c_pkg::PIX_W-1:0] mem [c3c_pkg::MAX_WIDTH];
   logic [c3c_pkg::PIX_W-1:0] rd_data_ff;

   // forward the word being written when the same entry is read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/c3c_row_cell.sv]
module c3c_row_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic [c3c_pkg::PIX_W-1:0]            pixel_in,
   input  logic [c3c_pkg::KROW_W-1:0]           coef_row,
   input  logic                                 row_ok,
   input  logic [2:0]                           col_ok,
   input  logic                                 sum_en,
   output logic signed [c3c_pkg::ROW_SUM_W-1:0] row_sum
);

   // tap 0 is the oldest column (left neighbor), tap 2 the newest
   logic [c3c_pkg::PIX_W-1:0]            tap_ff [3];
   logic [c3c_pkg::PIX_W-1:0]            tap_in [3];
   logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_ff;
   logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_in;

   always_comb begin
      tap_in[0] = tap_ff[0];
      tap_in[1] = tap_ff[1];
      tap_in[2] = tap_ff[2];
      if (shift_en) begin
         tap_in[0] = tap_ff[1];
         tap_in[1] = tap_ff[2];
         tap_in[2] = pixel_in;
      end
   end

   always_comb begin
      logic signed [c3c_pkg::PROD_W-1:0]    pix_s;
      logic signed [c3c_pkg::PROD_W-1:0]    coef_s;
      logic signed [c3c_pkg::PROD_W-1:0]    prod;
      logic signed [c3c_pkg::COEF_W-1:0]    coef_b;
      sum_in = '0;
      for (int c = 0; c < 3; c++) begin
         coef_b = coef_row[c*c3c_pkg::COEF_W +: c3c_pkg::COEF_W];
         pix_s  = $signed({{(c3c_pkg::PROD_W-c3c_pkg::PIX_W){1'b0}}, tap_ff[c]});
         coef_s = coef_b;
         prod   = pix_s * coef_s;
         if (row_ok && col_ok[c]) begin
            sum_in = sum_in + c3c_pkg::ROW_SUM_W'(prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff[0] <= '0;
         tap_ff[1] <= '0;
         tap_ff[2] <= '0;
      end else begin
         tap_ff <= tap_in;
      end
      if (sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign row_sum = sum_ff;

endmodule

[rtl/c3c_csr.sv]
module c3c_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [c3c_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [c3c_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [c3c_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output c3c_pkg::cfg_type               cfg
);

   c3c_pkg::cfg_type                 cfg_ff;
   c3c_pkg::cfg_type                 cfg_in;
   logic [c3c_pkg::REG_IDX_W-1:0]    reg_idx;

   assign reg_idx = paddr[c3c_pkg::CSR_ADDR_W-1:2];
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_idx)
            c3c_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = pwdata[c3c_pkg::COL_W-1:0];
            c3c_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = pwdata[c3c_pkg::ROW_W-1:0];
            c3c_pkg::REG_KERNEL_TOP:   cfg_in.kernel_top   = pwdata[c3c_pkg::KROW_W-1:0];
            c3c_pkg::REG_KERNEL_MID:   cfg_in.kernel_mid   = pwdata[c3c_pkg::KROW_W-1:0];
            c3c_pkg::REG_KERNEL_BOT:   cfg_in.kernel_bot   = pwdata[c3c_pkg::KROW_W-1:0];
            c3c_pkg::REG_FRAC_SHIFT:   cfg_in.frac_shift   = pwdata[c3c_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         c3c_pkg::REG_IMAGE_WIDTH:  prdata = c3c_pkg::CSR_DATA_W'(cfg_ff.image_width);
         c3c_pkg::REG_IMAGE_HEIGHT: prdata = c3c_pkg::CSR_DATA_W'(cfg_ff.image_height);
         c3c_pkg::REG_KERNEL_TOP:   prdata = c3c_pkg::CSR_DATA_W'(cfg_ff.kernel_top);
         c3c_pkg::REG_KERNEL_MID:   prdata = c3c_pkg::CSR_DATA_W'(cfg_ff.kernel_mid);
         c3c_pkg::REG_KERNEL_BOT:   prdata = c3c_pkg::CSR_DATA_W'(cfg_ff.kernel_bot);
         c3c_pkg::REG_FRAC_SHIFT:   prdata = c3c_pkg::CSR_DATA_W'(cfg_ff.frac_shift);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= c3c_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height <= c3c_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.kernel_top   <= c3c_pkg::RST_KERNEL_TOP;
         cfg_ff.kernel_mid   <= c3c_pkg::RST_KERNEL_MID;
         cfg_ff.kernel_bot   <= c3c_pkg::RST_KERNEL_BOT;
         cfg_ff.frac_shift   <= c3c_pkg::RST_FRAC_SHIFT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/conv2d_3x3_clamp.sv]
// Streaming 3x3 convolution, zero padded, result clamped to 0..255.
// One word per cycle in and out unless rsp_ready stalls; window and line buffers advance per word.
// Each result passes stage A (window load), B (row sums) and C (clamp register, drives
// rsp_valid); its completing word comes image_width+1 words after its pixel.
// Reset (sync, active high) clears counters, window and stage valids and loads CSR defaults;
// line buffer contents are not cleared and are never read before being written.
module conv2d_3x3_clamp (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [c3c_pkg::PIX_W-1:0]      req_pixel,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [c3c_pkg::PIX_W-1:0]      rsp_out_pixel,
   output logic                           rsp_out_last,

   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [c3c_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [c3c_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [c3c_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int COL_W = c3c_pkg::COL_W;
   localparam int ROW_W = c3c_pkg::ROW_W;

   c3c_pkg::cfg_type cfg;

   c3c_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ------------------------------------------------------------------
   // Pipeline handshake: stage A holds the window snapshot for one result,
   // stage B holds the row sums, stage C is the output register.
   // ------------------------------------------------------------------
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic c_free, b_free, a_free;
   logic a_move, b_move;
   logic accept;

   assign c_free    = !c_valid_ff || rsp_ready;
   assign b_move    = b_valid_ff && c_free;
   assign b_free    = !b_valid_ff || c_free;
   assign a_move    = a_valid_ff && b_free;
   // the window must hold while stage A still waits on it
   assign a_free    = !a_valid_ff || b_free;
   assign req_ready = a_free;
   assign accept    = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Effective frame size
   // ------------------------------------------------------------------
   logic [COL_W-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;

   always_comb begin
      if (cfg.image_width == '0) begin
         w_eff = COL_W'(1);
      end else if (cfg.image_width > COL_W'(c3c_pkg::MAX_WIDTH)) begin
         w_eff = COL_W'(c3c_pkg::MAX_WIDTH);
      end else begin
         w_eff = cfg.image_width;
      end
      h_eff = (cfg.image_height == '0) ? ROW_W'(1) : cfg.image_height;
   end

   // ------------------------------------------------------------------
   // Position counters
   // ------------------------------------------------------------------
   logic [COL_W-1:0] in_column_ff,  in_column_in;
   logic [ROW_W-1:0] in_row_ff,     in_row_in;
   logic [COL_W-1:0] out_column_ff, out_column_in;
   logic [ROW_W-1:0] out_row_ff,    out_row_in;

   logic                      emit;
   logic                      in_col_wrap;
   logic                      out_col_wrap;
   logic                      out_row_end;
   logic                      frame_last;
   logic [2:0]                row_ok;
   logic [2:0]                col_ok;
   logic [c3c_pkg::PIX_W-1:0] px;
   logic [c3c_pkg::PIX_W-1:0] up1;
   logic [c3c_pkg::PIX_W-1:0] up2;
   logic [c3c_pkg::PIX_W-1:0] lba_rdata;
   logic [c3c_pkg::PIX_W-1:0] lbb_rdata;

   assign px   = req_kind ? '0 : req_pixel;
   assign up1  = (in_row_ff != '0) ? lba_rdata : '0;
   assign up2  = (in_row_ff >= ROW_W'(2)) ? lbb_rdata : '0;
   assign emit = (in_row_ff >= ROW_W'(2)) ||
                 ((in_row_ff == ROW_W'(1)) && (in_column_ff != '0));

   assign in_col_wrap  = ({1'b0, in_column_ff} + (COL_W+1)'(1)) >= {1'b0, w_eff};
   assign out_col_wrap = ({1'b0, out_column_ff} + (COL_W+1)'(1)) >= {1'b0, w_eff};
   assign out_row_end  = ({1'b0, out_row_ff} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
   assign frame_last   = out_row_end && out_col_wrap;

   // edge masks for the result being formed; bit 0 is top row / left column
   assign row_ok = {!out_row_end, 1'b1, out_row_ff != '0};
   assign col_ok = {!out_col_wrap, 1'b1, out_column_ff != '0};

   always_comb begin
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (accept) begin
         if (in_col_wrap) begin
            in_column_in = '0;
            in_row_in    = in_row_ff + ROW_W'(1);
         end else begin
            in_column_in = in_column_ff + COL_W'(1);
         end
         if (emit) begin
            if (frame_last) begin
               // last result of the frame: restart every counter
               in_column_in  = '0;
               in_row_in     = '0;
               out_column_in = '0;
               out_row_in    = '0;
            end else if (out_col_wrap) begin
               out_column_in = '0;
               out_row_in    = out_row_ff + ROW_W'(1);
            end else begin
               out_column_in = out_column_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

   // ------------------------------------------------------------------
   // Line buffers: read ahead at the column of the next word so the data
   // sits in the read register when that word arrives.
   // ------------------------------------------------------------------
   logic [c3c_pkg::COL_ADDR_W-1:0] wr_col;
   logic [c3c_pkg::COL_ADDR_W-1:0] rd_col;

   assign wr_col = in_column_ff[c3c_pkg::COL_ADDR_W-1:0];
   assign rd_col = in_column_in[c3c_pkg::COL_ADDR_W-1:0];

   c3c_line_buffer u_line_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_col),
      .wr_data (px),
      .rd_addr (rd_col),
      .rd_data (lba_rdata)
   );

   c3c_line_buffer u_line_b (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_col),
      .wr_data (up1),
      .rd_addr (rd_col),
      .rd_data (lbb_rdata)
   );

   // ------------------------------------------------------------------
   // Stage A: masks and end-of-frame flag for the pending result
   // ------------------------------------------------------------------
   logic [2:0] a_row_ok_ff;
   logic [2:0] a_col_ok_ff;
   logic       a_last_ff;
   logic       b_last_ff;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_move) begin
         a_valid_in = 1'b0;
      end
      if (accept) begin
         a_valid_in = emit;
      end
      b_valid_in = b_valid_ff;
      if (b_move) begin
         b_valid_in = 1'b0;
      end
      if (a_move) begin
         b_valid_in = 1'b1;
      end
      c_valid_in = c_valid_ff;
      if (rsp_valid && rsp_ready) begin
         c_valid_in = 1'b0;
      end
      if (b_move) begin
         c_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
      if (accept && emit) begin
         a_row_ok_ff <= row_ok;
         a_col_ok_ff <= col_ok;
         a_last_ff   <= frame_last;
      end
      if (a_move) begin
         b_last_ff <= a_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Row cells: window rows shift on each accepted word, then form their
   // masked row sums into stage B.
   // ------------------------------------------------------------------
   logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_top;
   logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_mid;
   logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_bot;

   c3c_row_cell u_row_top (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .pixel_in (up2),
      .coef_row (cfg.kernel_top),
      .row_ok   (a_row_ok_ff[0]),
      .col_ok   (a_col_ok_ff),
      .sum_en   (a_move),
      .row_sum  (sum_top)
   );

   c3c_row_cell u_row_mid (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .pixel_in (up1),
      .coef_row (cfg.kernel_mid),
      .row_ok   (a_row_ok_ff[1]),
      .col_ok   (a_col_ok_ff),
      .sum_en   (a_move),
      .row_sum  (sum_mid)
   );

   c3c_row_cell u_row_bot (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .pixel_in (px),
      .coef_row (cfg.kernel_bot),
      .row_ok   (a_row_ok_ff[2]),
      .col_ok   (a_col_ok_ff),
      .sum_en   (a_move),
      .row_sum  (sum_bot)
   );

   // ------------------------------------------------------------------
   // Stage C: total, drop negatives to zero, shift, saturate at 255
   // ------------------------------------------------------------------
   logic signed [c3c_pkg::TOTAL_W-1:0] total;
   logic [c3c_pkg::TOTAL_W-1:0]        shifted;
   logic [c3c_pkg::PIX_W-1:0]          clamped;
   logic [c3c_pkg::PIX_W-1:0]          out_pixel_ff;
   logic                               out_last_ff;

   always_comb begin
      total   = c3c_pkg::TOTAL_W'(sum_top) + c3c_pkg::TOTAL_W'(sum_mid)
              + c3c_pkg::TOTAL_W'(sum_bot);
      shifted = $unsigned(total) >> cfg.frac_shift;
      if (total[c3c_pkg::TOTAL_W-1]) begin
         clamped = '0;
      end else if (shifted > c3c_pkg::TOTAL_W'(c3c_pkg::PIX_MAX)) begin
         clamped = c3c_pkg::PIX_MAX;
      end else begin
         clamped = shifted[c3c_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         out_pixel_ff <= clamped;
         out_last_ff  <= b_last_ff;
      end
   end

   assign rsp_valid     = c_valid_ff;
   assign rsp_out_pixel = out_pixel_ff;
   assign rsp_out_last  = out_last_ff;

endmodule
